@@ rtl/lcs_pkg.sv @@
// shared types and constants for the local to utc calendar shift pipeline
// no dependencies; used by every stage module and the top level

package lcs_pkg;

  // one calendar time record as it moves down the pipe
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } item_t;

  // per-stage control: item valid and the day step direction
  typedef struct packed {
    logic valid;
    logic fwd;
    logic bwd;
  } ctl_t;

  // length of the current and of the previous month
  typedef struct packed {
    logic [4:0] cur;
    logic [4:0] prev;
  } mlen_t;

  localparam int          PROD_W      = 27;
  localparam int          QUOT_W      = 10;
  localparam int          RECIP_SHIFT = 17;
  // floor(y / 25) == (y * 5243) >> 17 for every 14-bit y
  localparam logic [12:0] RECIP_25    = 13'd5243;

  localparam logic signed [6:0] HOURS_PER_DAY = 7'sd24;
  localparam logic [3:0]        MONTHS        = 4'd12;
  localparam logic [2:0]        WEEKDAY_LAST  = 3'd7;
  localparam logic [2:0]        WEEKDAY_FIRST = 3'd1;

  // months outside 1..12 take february lengths
  function automatic mlen_t month_len(input logic [3:0] month, input logic leap);
    mlen_t      l;
    logic [4:0] feb;
    feb = leap ? 5'd29 : 5'd28;
    if (month inside {4'd1, 4'd8}) begin
      l.cur  = 5'd31;
      l.prev = 5'd31;
    end else if (month == 4'd3) begin
      l.cur  = 5'd31;
      l.prev = feb;
    end else if (month inside {4'd5, 4'd7, 4'd10, 4'd12}) begin
      l.cur  = 5'd31;
      l.prev = 5'd30;
    end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      l.cur  = 5'd30;
      l.prev = 5'd31;
    end else begin
      l.cur  = feb;
      l.prev = 5'd31;
    end
    return l;
  endfunction

endpackage

@@ rtl/local_to_utc_calendar_shift.sv @@
// top level of the local to utc calendar shift: offset register and three stages
// depends on lcs_pkg, lcs_shift, lcs_len, lcs_roll
//
//  channel   handshake          payload
//  -------   ----------------   ------------------------------------------------
//  config    cfg_we             cfg_wdata (signed hour offset)
//  input     start, busy        year_in month_in day_in hour_in minute_in
//                               second_in weekday_in
//  result    done (strobe)      year_out month_out day_out hour_out minute_out
//                               second_out weekday_out
//
// an item is taken at every clock edge with start high and busy low; its result
// shows on done after the three register stages (hour add and multiply, leap test,
// roll over), one item per cycle sustained.
// busy is high only while rst is held; rst clears the offset and all valid bits.
// done is a one-cycle strobe; the receiver cannot hold results off.

module local_to_utc_calendar_shift (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic signed [5:0] cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  logic [13:0]       year_in,
  input  logic [3:0]        month_in,
  input  logic [4:0]        day_in,
  input  logic [4:0]        hour_in,
  input  logic [5:0]        minute_in,
  input  logic [5:0]        second_in,
  input  logic [2:0]        weekday_in,
  output logic              done,
  output logic [13:0]       year_out,
  output logic [3:0]        month_out,
  output logic [4:0]        day_out,
  output logic [4:0]        hour_out,
  output logic [5:0]        minute_out,
  output logic [5:0]        second_out,
  output logic [2:0]        weekday_out
);

  logic signed [5:0]                tz_offset_hours;
  lcs_pkg::item_t                   in_item;
  lcs_pkg::item_t                   s1_item;
  lcs_pkg::item_t                   s2_item;
  lcs_pkg::item_t                   s3_item;
  lcs_pkg::ctl_t                    s1_ctl;
  lcs_pkg::ctl_t                    s2_ctl;
  lcs_pkg::mlen_t                   s2_len;
  logic [lcs_pkg::PROD_W-1:0]       s1_prod;
  logic                             in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tz_offset_hours <= '0;
    end else if (cfg_we) begin
      tz_offset_hours <= cfg_wdata;
    end
  end

  assign busy     = rst;
  assign in_valid = start & ~busy;

  always_comb begin
    in_item.year    = year_in;
    in_item.month   = month_in;
    in_item.day     = day_in;
    in_item.hour    = hour_in;
    in_item.minute  = minute_in;
    in_item.second  = second_in;
    in_item.weekday = weekday_in;
  end

  lcs_shift u_shift (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .tz       (tz_offset_hours),
    .s1_item  (s1_item),
    .s1_ctl   (s1_ctl),
    .s1_prod  (s1_prod)
  );

  lcs_len u_len (
    .clk     (clk),
    .rst     (rst),
    .s1_item (s1_item),
    .s1_ctl  (s1_ctl),
    .s1_prod (s1_prod),
    .s2_item (s2_item),
    .s2_ctl  (s2_ctl),
    .s2_len  (s2_len)
  );

  lcs_roll u_roll (
    .clk      (clk),
    .rst      (rst),
    .s2_item  (s2_item),
    .s2_ctl   (s2_ctl),
    .s2_len   (s2_len),
    .s3_valid (done),
    .s3_item  (s3_item)
  );

  assign year_out    = s3_item.year;
  assign month_out   = s3_item.month;
  assign day_out     = s3_item.day;
  assign hour_out    = s3_item.hour;
  assign minute_out  = s3_item.minute;
  assign second_out  = s3_item.second;
  assign weekday_out = s3_item.weekday;

endmodule

@@ rtl/lcs_shift.sv @@
// stage 1: hour offset add, day step direction, year times reciprocal of 25
// depends on lcs_pkg

module lcs_shift (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  lcs_pkg::item_t     in_item,
  input  logic signed [5:0]  tz,
  output lcs_pkg::item_t     s1_item,
  output lcs_pkg::ctl_t      s1_ctl,
  output logic [lcs_pkg::PROD_W-1:0] s1_prod
);

  logic signed [6:0]           hour_sum;
  logic signed [6:0]           hour_adj;
  logic                        fwd;
  logic                        bwd;
  logic [lcs_pkg::PROD_W-1:0]  prod;
  lcs_pkg::item_t              item_next;

  always_comb begin
    hour_sum = $signed({2'b00, in_item.hour}) + $signed({tz[5], tz});
    fwd      = (hour_sum >= lcs_pkg::HOURS_PER_DAY);
    bwd      = hour_sum[6];
    if (fwd) begin
      hour_adj = hour_sum - lcs_pkg::HOURS_PER_DAY;
    end else if (bwd) begin
      hour_adj = hour_sum + lcs_pkg::HOURS_PER_DAY;
    end else begin
      hour_adj = hour_sum;
    end
    item_next      = in_item;
    item_next.hour = hour_adj[4:0];
    prod = lcs_pkg::PROD_W'(in_item.year) * lcs_pkg::PROD_W'(lcs_pkg::RECIP_25);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.valid <= in_valid;
      s1_ctl.fwd   <= fwd;
      s1_ctl.bwd   <= bwd;
    end
  end

  always_ff @(posedge clk) begin
    s1_item <= item_next;
    s1_prod <= prod;
  end

endmodule

@@ rtl/lcs_len.sv @@
// stage 2: leap year test from the quotient by 25, month length lookup
// depends on lcs_pkg

module lcs_len (
  input  logic                       clk,
  input  logic                       rst,
  input  lcs_pkg::item_t             s1_item,
  input  lcs_pkg::ctl_t              s1_ctl,
  input  logic [lcs_pkg::PROD_W-1:0] s1_prod,
  output lcs_pkg::item_t             s2_item,
  output lcs_pkg::ctl_t              s2_ctl,
  output lcs_pkg::mlen_t             s2_len
);

  logic [lcs_pkg::QUOT_W-1:0] quot;
  logic [13:0]                quot25;
  logic                       div25;
  logic                       leap;
  lcs_pkg::mlen_t             len_next;

  always_comb begin
    quot   = s1_prod[lcs_pkg::RECIP_SHIFT +: lcs_pkg::QUOT_W];
    // quot * 25 as shift and add
    quot25 = 14'({quot, 4'b0000}) + 14'({quot, 3'b000}) + 14'(quot);
    div25  = (quot25 == s1_item.year);
    // by 400 is by 16 and 25, by 100 is by 4 and 25
    leap   = div25 ? (s1_item.year[3:0] == 4'd0) : (s1_item.year[1:0] == 2'd0);
    len_next = lcs_pkg::month_len(s1_item.month, leap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s2_item <= s1_item;
    s2_len  <= len_next;
  end

endmodule

@@ rtl/lcs_roll.sv @@
// stage 3: day, weekday, month and year roll over, result register
// depends on lcs_pkg

module lcs_roll (
  input  logic            clk,
  input  logic            rst,
  input  lcs_pkg::item_t  s2_item,
  input  lcs_pkg::ctl_t   s2_ctl,
  input  lcs_pkg::mlen_t  s2_len,
  output logic            s3_valid,
  output lcs_pkg::item_t  s3_item
);

  lcs_pkg::item_t item_next;
  logic [5:0]     day_inc;
  logic [4:0]     month_inc;

  always_comb begin
    item_next = s2_item;
    day_inc   = {1'b0, s2_item.day} + 6'd1;
    month_inc = {1'b0, s2_item.month} + 5'd1;
    if (s2_ctl.fwd) begin
      item_next.weekday = (s2_item.weekday == lcs_pkg::WEEKDAY_LAST) ?
                          lcs_pkg::WEEKDAY_FIRST : s2_item.weekday + 3'd1;
      if (day_inc > {1'b0, s2_len.cur}) begin
        item_next.day = 5'(day_inc - {1'b0, s2_len.cur});
        if (month_inc > {1'b0, lcs_pkg::MONTHS}) begin
          item_next.month = 4'(month_inc - {1'b0, lcs_pkg::MONTHS});
          item_next.year  = s2_item.year + 14'd1;
        end else begin
          item_next.month = month_inc[3:0];
        end
      end else begin
        item_next.day = day_inc[4:0];
      end
    end else if (s2_ctl.bwd) begin
      // weekday zero also steps back to the last day of the week
      item_next.weekday = (s2_item.weekday <= lcs_pkg::WEEKDAY_FIRST) ?
                          lcs_pkg::WEEKDAY_LAST : s2_item.weekday - 3'd1;
      if (s2_item.day <= 5'd1) begin
        item_next.day = s2_len.prev;
        if (s2_item.month <= 4'd1) begin
          item_next.month = lcs_pkg::MONTHS;
          item_next.year  = s2_item.year - 14'd1;
        end else begin
          item_next.month = s2_item.month - 4'd1;
        end
      end else begin
        item_next.day = s2_item.day - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_item <= item_next;
  end

endmodule

@@ rtl/lcs_checker.sv @@
// port-level checks for local_to_utc_calendar_shift, attached by bind
// depends on the top level's port list only

module lcs_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [5:0]        minute_in,
  input logic [5:0]        second_in,
  input logic [2:0]        weekday_in,
  input logic              done,
  input logic [5:0]        minute_out,
  input logic [5:0]        second_out,
  input logic [2:0]        weekday_out
);

  // every accepted item not cut off by a reset comes out on done
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    $past(start && !busy, 3) && !$past(rst, 1) && !$past(rst, 2) |-> done)
    else $error("accepted item gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without an accepted item");

  // minute and second ride through untouched
  a_min_sec: assert property (@(posedge clk) disable iff (rst)
    done |-> (minute_out == $past(minute_in, 3)) && (second_out == $past(second_in, 3)))
    else $error("minute or second changed");

  // a weekday comes out zero only if it went in as zero
  a_weekday: assert property (@(posedge clk) disable iff (rst)
    done |-> (weekday_out != 3'd0) || ($past(weekday_in, 3) == 3'd0))
    else $error("weekday zero after shift");

endmodule

bind local_to_utc_calendar_shift lcs_checker u_lcs_checker (.*);

@@ bench/lcs_checker.sv @@
// checker for the local to utc calendar shift: tracks the offset register, predicts
// each utc record from the local one taken in and compares it with what comes out
// depends on lcs_pkg for the record layout

module lcs_shift_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic signed [5:0] cfg_wdata,
  input  logic              start,
  input  logic              busy,
  input  lcs_pkg::item_t    loc_time,
  input  logic              done,
  input  lcs_pkg::item_t    utc_rec,
  output int                mismatches,
  output int                pending
);

  logic signed [5:0] tz_hours;
  lcs_pkg::item_t    utc_expected[$];

  function automatic bit leap_year(input int y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic lcs_pkg::item_t shift_to_utc(input lcs_pkg::item_t t,
                                                  input logic signed [5:0] tz);
    int             y;
    int             mon;
    int             d;
    int             h;
    int             wd;
    int             feb;
    int             days_now;
    int             days_prev;
    lcs_pkg::item_t r;
    y   = t.year;
    mon = t.month;
    d   = t.day;
    h   = int'(t.hour) + int'(tz);
    wd  = t.weekday;
    // leap test is on the local year, before any year step
    feb = leap_year(y) ? 29 : 28;
    case (mon)
      1, 8: begin
        days_now  = 31;
        days_prev = 31;
      end
      3: begin
        days_now  = 31;
        days_prev = feb;
      end
      5, 7, 10, 12: begin
        days_now  = 31;
        days_prev = 30;
      end
      4, 6, 9, 11: begin
        days_now  = 30;
        days_prev = 31;
      end
      default: begin
        // out of range months count as february
        days_now  = feb;
        days_prev = 31;
      end
    endcase

    if (h >= 24) begin
      h  = h - 24;
      d  = d + 1;
      wd = wd + 1;
      if (wd > 7) wd = 1;
      if (d > days_now) begin
        d   = d - days_now;
        mon = mon + 1;
        if (mon > 12) begin
          mon = mon - 12;
          y   = y + 1;
        end
      end
    end

    if (h < 0) begin
      h  = h + 24;
      d  = d - 1;
      wd = wd - 1;
      if (wd < 1) wd = 7;
      if (d < 1) begin
        d   = days_prev;
        mon = mon - 1;
        if (mon < 1) begin
          mon = 12;
          y   = y - 1;
        end
      end
    end

    r.year    = y[13:0];
    r.month   = mon[3:0];
    r.day     = d[4:0];
    r.hour    = h[4:0];
    r.minute  = t.minute;
    r.second  = t.second;
    r.weekday = wd[2:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lcs_pkg::item_t want;
    if (rst) begin
      tz_hours <= '0;
      utc_expected.delete();
    end else begin
      if (cfg_we) tz_hours <= cfg_wdata;
      // compare before pushing: an item taken now is never the one finishing now
      if (done) begin
        if (utc_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no item outstanding: y%0d m%0d d%0d h%0d %0d:%0d wd%0d",
                     $time, utc_rec.year, utc_rec.month, utc_rec.day, utc_rec.hour,
                     utc_rec.minute, utc_rec.second, utc_rec.weekday);
        end else begin
          want = utc_expected.pop_front();
          if (utc_rec !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: mismatch, expected y%0d m%0d d%0d h%0d %0d:%0d wd%0d,",
                     $time, want.year, want.month, want.day, want.hour, want.minute,
                     want.second, want.weekday);
              $display(" got y%0d m%0d d%0d h%0d %0d:%0d wd%0d",
                       utc_rec.year, utc_rec.month, utc_rec.day, utc_rec.hour,
                       utc_rec.minute, utc_rec.second, utc_rec.weekday);
            end
          end
        end
      end
      if (start && !busy) utc_expected.push_back(shift_to_utc(loc_time, tz_hours));
    end
    pending = utc_expected.size();
  end

endmodule

@@ bench/tb_local_to_utc_calendar_shift.sv @@
// testbench top for local_to_utc_calendar_shift: clock, reset, offset writes, items
// in directed and random phases, watchdog and verdict
// depends on lcs_pkg, the block itself and lcs_shift_checker

module tb_local_to_utc_calendar_shift;

  localparam int N_PHASES       = 10;
  localparam int PHASE_ITEMS    = 155;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 8;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic signed [5:0] cfg_wdata = '0;
  logic              start     = 1'b0;
  logic              busy;
  lcs_pkg::item_t    loc_time  = '0;
  logic              done;
  logic [13:0]       year_out;
  logic [3:0]        month_out;
  logic [4:0]        day_out;
  logic [4:0]        hour_out;
  logic [5:0]        minute_out;
  logic [5:0]        second_out;
  logic [2:0]        weekday_out;
  lcs_pkg::item_t    utc_rec;
  int                mismatches;
  int                pending;
  int                idle_cycles = 0;
  bit                burst       = 1'b0;
  int                phase_tz[N_PHASES] = '{23, -23, 31, -32, 0, -8, 5, -1, 1, 12};

  assign utc_rec = {year_out, month_out, day_out, hour_out, minute_out, second_out,
                    weekday_out};

  always #2 clk = ~clk;

  local_to_utc_calendar_shift u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .year_in    (loc_time.year),
    .month_in   (loc_time.month),
    .day_in     (loc_time.day),
    .hour_in    (loc_time.hour),
    .minute_in  (loc_time.minute),
    .second_in  (loc_time.second),
    .weekday_in (loc_time.weekday),
    .done       (done),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out),
    .hour_out   (hour_out),
    .minute_out (minute_out),
    .second_out (second_out),
    .weekday_out(weekday_out)
  );

  lcs_shift_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .loc_time  (loc_time),
    .done      (done),
    .utc_rec   (utc_rec),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // ends the run if nothing goes in or comes out for too long
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic lcs_pkg::item_t stamp(input int y, input int mon, input int d,
                                           input int h, input int mi, input int s,
                                           input int wd);
    lcs_pkg::item_t t;
    t.year    = y[13:0];
    t.month   = mon[3:0];
    t.day     = d[4:0];
    t.hour    = h[4:0];
    t.minute  = mi[5:0];
    t.second  = s[5:0];
    t.weekday = wd[2:0];
    return t;
  endfunction

  function automatic lcs_pkg::item_t random_local();
    lcs_pkg::item_t t;
    case ($urandom_range(0, 9))
      6:       t.year = 14'($urandom_range(0, 2499) * 4);
      7:       t.year = 14'($urandom_range(0, 99) * 100);
      8: begin
        case ($urandom_range(0, 3))
          0:       t.year = 14'd0;
          1:       t.year = 14'd16383;
          2:       t.year = 14'd16382;
          default: t.year = 14'd9999;
        endcase
      end
      9:       t.year = 14'($urandom_range(0, 16383));
      default: t.year = 14'($urandom_range(1, 9998));
    endcase
    t.month = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 12));
    // lean on month ends and month starts so the roll over gets exercised
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t.day = 5'($urandom_range(27, 31));
      4, 5:       t.day = 5'd1;
      6:          t.day = 5'($urandom_range(0, 31));
      default:    t.day = 5'($urandom_range(1, 28));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: t.hour = 5'($urandom_range(0, 3));
      3, 4, 5: t.hour = 5'($urandom_range(20, 23));
      6:       t.hour = 5'($urandom_range(0, 31));
      default: t.hour = 5'($urandom_range(0, 23));
    endcase
    t.minute  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 59));
    t.second  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 59));
    t.weekday = 3'($urandom_range(0, 7));
    return t;
  endfunction

  // start stays high across back to back items; send_item lowers it only for a gap
  task automatic send_item(input lcs_pkg::item_t t);
    int gap;
    if ($urandom_range(0, 31) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    loc_time <= t;
    start    <= 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // offset is only changed once the pipe has drained
  task automatic write_offset(input int v);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata <= v[5:0];
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // one hour forward, mostly from 23:xx
    write_offset(1);
    send_item(stamp(2023, 12, 31, 23, 0, 0, 7));
    send_item(stamp(2024, 2, 28, 23, 59, 59, 3));
    send_item(stamp(2024, 2, 29, 23, 63, 63, 4));
    send_item(stamp(2023, 2, 28, 23, 1, 2, 2));
    send_item(stamp(1900, 2, 28, 23, 30, 30, 5));
    send_item(stamp(2000, 2, 28, 23, 45, 15, 1));
    send_item(stamp(2023, 4, 31, 23, 10, 20, 6));
    send_item(stamp(2023, 0, 29, 23, 5, 5, 2));
    send_item(stamp(2023, 15, 29, 23, 6, 6, 3));
    send_item(stamp(16383, 12, 31, 23, 7, 7, 0));
    send_item(stamp(9998, 6, 0, 10, 0, 59, 7));
    send_item(stamp(1, 1, 31, 31, 63, 0, 1));

    // one hour back, mostly from 00:xx
    write_offset(-1);
    send_item(stamp(2024, 3, 1, 0, 0, 0, 1));
    send_item(stamp(2023, 3, 1, 0, 59, 59, 7));
    send_item(stamp(2024, 1, 1, 0, 12, 34, 1));
    send_item(stamp(2023, 8, 1, 0, 1, 1, 4));
    send_item(stamp(2023, 5, 1, 0, 2, 2, 5));
    send_item(stamp(2023, 0, 1, 0, 3, 3, 6));
    send_item(stamp(0, 1, 1, 0, 63, 63, 2));
    send_item(stamp(2023, 6, 15, 0, 4, 4, 0));
    send_item(stamp(2023, 7, 0, 0, 5, 5, 3));
    send_item(stamp(2023, 15, 1, 0, 6, 6, 1));
    send_item(stamp(2023, 11, 20, 12, 7, 7, 2));

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == N_PHASES - 1) write_offset($urandom_range(0, 63));
      else write_offset(phase_tz[p]);
      repeat (PHASE_ITEMS) send_item(random_local());
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lcs_pkg.sv
rtl/lcs_shift.sv
rtl/lcs_len.sv
rtl/lcs_roll.sv
rtl/local_to_utc_calendar_shift.sv
rtl/lcs_checker.sv
bench/lcs_checker.sv
bench/tb_local_to_utc_calendar_shift.sv
